>>> sv/brt_pkg.sv
package brt_pkg;

    // Sizing
    localparam int MAX_INITIATORS = 8;
    localparam int MAX_TARGETS    = 16;
    localparam int FIFO_DEPTH     = 16;
    localparam int ADDR_WIDTH     = 32;

    localparam int MASK_W  = 8;
    localparam int MID_W   = 3;
    localparam int TGT_W   = 4;
    localparam int BLK_W   = 8;
    localparam int NT_W    = 5;
    localparam int NI_W    = 4;
    localparam int PTR_W   = $clog2(FIFO_DEPTH);
    localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);

    // Address remainder, one byte per cycle
    localparam int DIV_BITS  = 8;
    localparam int DIV_STEPS = (ADDR_WIDTH + DIV_BITS - 1) / DIV_BITS;
    localparam int DIV_W     = DIV_STEPS * DIV_BITS;
    localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Configuration
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_TARGETS    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_INITIATORS = 1'd1;
    localparam logic [NT_W-1:0]      NT_RESET           = 5'd1;
    localparam logic [NI_W-1:0]      NI_RESET           = 4'd8;

    // Result status codes
    localparam int STATUS_W = 3;
    localparam logic [STATUS_W-1:0] ST_FWD      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_STALL    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NONE     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RESP     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RESP_ERR = 3'd4;

    // Input opcodes
    localparam logic OP_REQUEST  = 1'b0;
    localparam logic OP_RESPONSE = 1'b1;

    typedef enum logic [1:0] {
        K_NONE  = 2'd0,
        K_WRITE = 2'd1,
        K_READ  = 2'd2,
        K_RESP  = 2'd3
    } t_kind;

    // Classified transaction handed from front to back
    typedef struct packed {
        t_kind              kind;
        logic [MID_W-1:0]   master;
        logic [TGT_W-1:0]   target;
        logic [BLK_W-1:0]   blk;
    } t_cmd;

endpackage

>>> sv/brt_ram.sv
module brt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/brt_front.sv
module brt_front
    import brt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_opcode,
    input  logic [MASK_W-1:0]     i_pending_mask,
    input  logic [ADDR_WIDTH-1:0] i_req_address,
    input  logic                  i_req_is_read,
    input  logic [BLK_W-1:0]      i_req_block_size,
    input  logic [BLK_W-1:0]      i_resp_block_size,
    output logic                  o_push,
    output t_cmd                  o_cmd,
    input  logic                  i_full
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate           r_state, n_state;
    logic [NT_W-1:0]   r_nt;
    logic [NI_W-1:0]   r_ni;
    logic [NT_W-1:0]   r_nt_eff, n_nt_eff;
    logic [DIV_W-1:0]  r_addr, n_addr;
    logic [TGT_W-1:0]  r_rem, n_rem;
    logic [STEP_W-1:0] r_step, n_step;
    t_cmd              r_cmd, n_cmd;

    logic [NI_W-1:0]   ni_eff;
    logic [MID_W-1:0]  winner;
    logic              found;
    logic [TGT_W-1:0]  rem_step;
    logic [NT_W-1:0]   trial;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nt <= NT_RESET;
            r_ni <= NI_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NUM_TARGETS:    r_nt <= i_cfg_data;
                CFG_NUM_INITIATORS: r_ni <= i_cfg_data[NI_W-1:0];
                default:            ;
            endcase
        end
    end

    // Fixed priority: highest-numbered pending master below the master count
    always_comb begin
        ni_eff = (r_ni > NI_W'(MAX_INITIATORS)) ? NI_W'(MAX_INITIATORS) : r_ni;
        winner = '0;
        found  = 1'b0;
        for (int i = 0; i < MASK_W; i++) begin
            if (i_pending_mask[i] && (NI_W'(i) < ni_eff)) begin
                winner = MID_W'(i);
                found  = 1'b1;
            end
        end
    end

    // One byte of the address remainder: eight restoring steps
    always_comb begin
        rem_step = r_rem;
        trial    = '0;
        for (int b = 0; b < DIV_BITS; b++) begin
            trial = {rem_step, r_addr[DIV_W-1-b]};
            if (trial >= r_nt_eff) begin
                trial = trial - r_nt_eff;
            end
            rem_step = trial[TGT_W-1:0];
        end
    end

    // Classify and sequence
    always_comb begin
        n_state  = r_state;
        n_nt_eff = r_nt_eff;
        n_addr   = r_addr;
        n_rem    = r_rem;
        n_step   = r_step;
        n_cmd    = r_cmd;
        case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    n_cmd.master = winner;
                    n_cmd.target = '0;
                    n_cmd.blk    = i_req_block_size;
                    if (i_opcode == OP_RESPONSE) begin
                        n_cmd.kind   = K_RESP;
                        n_cmd.master = '0;
                        n_cmd.blk    = i_resp_block_size;
                        n_state      = F_PUSH;
                    end else if (!found) begin
                        n_cmd.kind   = K_NONE;
                        n_cmd.blk    = '0;
                        n_state      = F_PUSH;
                    end else begin
                        n_cmd.kind = i_req_is_read ? K_READ : K_WRITE;
                        n_addr     = DIV_W'(i_req_address);
                        n_rem      = '0;
                        n_step     = '0;
                        if (r_nt == '0) begin
                            n_nt_eff = NT_W'(1);
                        end else if (r_nt > NT_W'(MAX_TARGETS)) begin
                            n_nt_eff = NT_W'(MAX_TARGETS);
                        end else begin
                            n_nt_eff = r_nt;
                        end
                        n_state = F_DIV;
                    end
                end
            end
            F_DIV: begin
                n_rem  = rem_step;
                n_addr = r_addr << DIV_BITS;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_cmd.target = rem_step;
                    n_state      = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_nt_eff <= n_nt_eff;
        r_addr   <= n_addr;
        r_rem    <= n_rem;
        r_step   <= n_step;
        r_cmd    <= n_cmd;
    end

    assign o_ready = (r_state == F_IDLE);
    assign o_push  = (r_state == F_PUSH) && !i_full;
    assign o_cmd   = r_cmd;

endmodule

>>> sv/brt_queue.sv
module brt_queue
    import brt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Hold queued commands
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> sv/brt_back.sv
module brt_back
    import brt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  t_cmd                i_cmd,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [MID_W-1:0]    o_grant_master,
    output logic [TGT_W-1:0]    o_target_index,
    output logic [BLK_W-1:0]    o_bus_cycles,
    output logic [CNT_W-1:0]    o_outstanding_count
);

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_POP  = 2'b10
    } t_bstate;

    t_bstate             r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [TGT_W-1:0]    r_last, n_last;
    logic [PTR_W-1:0]    r_head, n_head;
    logic [PTR_W-1:0]    r_tail, n_tail;
    logic [BLK_W-1:0]    r_resp_blk, n_resp_blk;
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [MID_W-1:0]    r_master, n_master;
    logic [TGT_W-1:0]    r_target, n_target;
    logic [BLK_W-1:0]    r_cycles, n_cycles;
    logic [CNT_W-1:0]    r_out_cnt, n_out_cnt;

    logic                out_free;
    logic                ram_we;
    logic [MID_W-1:0]    ram_rdata;

    // Master id ordering memory, read address follows the head
    brt_ram #(
        .WIDTH (MID_W),
        .DEPTH (FIFO_DEPTH)
    ) u_mid_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata (i_cmd.master),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    assign out_free = !r_out_valid || i_ready;

    // Execute one command per slot of the output register
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_last      = r_last;
        n_head      = r_head;
        n_tail      = r_tail;
        n_resp_blk  = r_resp_blk;
        n_out_valid = r_out_valid && !i_ready;
        n_status    = r_status;
        n_master    = r_master;
        n_target    = r_target;
        n_cycles    = r_cycles;
        n_out_cnt   = r_out_cnt;
        o_pop       = 1'b0;
        ram_we      = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (i_valid && out_free) begin
                    o_pop       = 1'b1;
                    n_out_valid = 1'b1;
                    n_master    = i_cmd.master;
                    n_target    = i_cmd.target;
                    n_cycles    = '0;
                    n_out_cnt   = r_count;
                    case (i_cmd.kind)
                        K_NONE: begin
                            n_status = ST_NONE;
                            n_master = '0;
                            n_target = '0;
                        end
                        K_WRITE: begin
                            n_status = ST_FWD;
                            n_cycles = i_cmd.blk;
                        end
                        K_READ: begin
                            if (((i_cmd.target != r_last) && (r_count != '0)) ||
                                (r_count >= CNT_W'(FIFO_DEPTH))) begin
                                n_status = ST_STALL;
                            end else begin
                                ram_we    = 1'b1;
                                n_tail    = r_tail + PTR_W'(1);
                                n_count   = r_count + CNT_W'(1);
                                n_last    = i_cmd.target;
                                n_status  = ST_FWD;
                                n_cycles  = BLK_W'(1);
                                n_out_cnt = r_count + CNT_W'(1);
                            end
                        end
                        K_RESP: begin
                            if (r_count == '0) begin
                                n_status = ST_RESP_ERR;
                                n_master = '0;
                                n_target = r_last;
                            end else begin
                                // wait for the registered memory read
                                n_out_valid = r_out_valid && !i_ready;
                                n_resp_blk  = i_cmd.blk;
                                n_state     = B_POP;
                            end
                        end
                        default: n_status = ST_NONE;
                    endcase
                end
            end
            B_POP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_RESP;
                    n_master    = ram_rdata;
                    n_target    = r_last;
                    n_cycles    = r_resp_blk;
                    n_head      = r_head + PTR_W'(1);
                    n_count     = r_count - CNT_W'(1);
                    n_out_cnt   = r_count - CNT_W'(1);
                    n_state     = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_count     <= '0;
            r_last      <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_last      <= n_last;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_out_valid <= n_out_valid;
        end
        r_resp_blk <= n_resp_blk;
        r_status   <= n_status;
        r_master   <= n_master;
        r_target   <= n_target;
        r_cycles   <= n_cycles;
        r_out_cnt  <= n_out_cnt;
    end

    assign o_valid             = r_out_valid;
    assign o_status            = r_status;
    assign o_grant_master      = r_master;
    assign o_target_index      = r_target;
    assign o_bus_cycles        = r_cycles;
    assign o_outstanding_count = r_out_cnt;

    // Outstanding count never passes the memory depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_DEPTH))
        else $error("outstanding count above depth");

    // Pointer distance matches the outstanding count
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tail - r_head) == r_count[PTR_W-1:0])
        else $error("pointers disagree with outstanding count");

    // A pop is only started with reads outstanding
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_POP) |-> (r_count != '0))
        else $error("pop with nothing outstanding");

    // A memory write always raises the count by one
    a_write_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("memory write without count increment");

endmodule

>>> sv/bus_router_read_tracker.sv
// Shared-bus router with fixed-priority arbitration and read-response ordering.
// A request transaction (tuser 0) is granted to the highest-numbered pending
// master below num_initiators and routed to target address mod num_targets;
// a response transaction (tuser 1) returns the oldest waiting read master.
// One result transaction per input transaction. The front stage takes a
// request through accept, one address byte per cycle through the target
// remainder unit, and hand-off, and a response or an empty request straight
// from accept to hand-off. A two-entry queue feeds the back stage, which
// retires one transaction per cycle while its result register is free; a
// response reading the master-id memory also passes the pop state. The front
// takes no new transaction before hand-off; the queue lets one enter while a
// result waits on m_tready. Configuration writes apply at the next cycle.
module bus_router_read_tracker
    import brt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // pending_mask[7:0], req_address[39:8], req_is_read[40],
    // req_block_size[48:41], resp_block_size[56:49], zero[63:57]
    input  logic [63:0]           s_tdata,
    // opcode[0]
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // grant_master[2:0], target_index[6:3], bus_cycles[14:7],
    // outstanding_count[19:15], zero[23:20]
    output logic [23:0]           m_tdata,
    // status[2:0]
    output logic [2:0]            m_tuser
);

    logic front_push;
    t_cmd front_cmd;
    logic q_full, q_valid, q_pop;
    t_cmd q_cmd;

    logic [MID_W-1:0] grant_master;
    logic [TGT_W-1:0] target_index;
    logic [BLK_W-1:0] bus_cycles;
    logic [CNT_W-1:0] outstanding_count;

    // Accept and classify
    brt_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (s_tvalid),
        .o_ready           (s_tready),
        .i_opcode          (s_tuser),
        .i_pending_mask    (s_tdata[7:0]),
        .i_req_address     (s_tdata[39:8]),
        .i_req_is_read     (s_tdata[40]),
        .i_req_block_size  (s_tdata[48:41]),
        .i_resp_block_size (s_tdata[56:49]),
        .o_push            (front_push),
        .o_cmd             (front_cmd),
        .i_full            (q_full)
    );

    // Decouple front and back
    brt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    // Track reads and produce results
    brt_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (q_valid),
        .i_cmd               (q_cmd),
        .o_pop               (q_pop),
        .o_valid             (m_tvalid),
        .i_ready             (m_tready),
        .o_status            (m_tuser),
        .o_grant_master      (grant_master),
        .o_target_index      (target_index),
        .o_bus_cycles        (bus_cycles),
        .o_outstanding_count (outstanding_count)
    );

    assign m_tdata = {4'b0000, outstanding_count, bus_cycles, target_index, grant_master};

endmodule
